@@ rtl/qtpi_pkg.sv @@
// Shared types and constants for the quintic trajectory PI joint controller.
`default_nettype none
package qtpi_pkg;

  localparam int NUM_JOINTS = 3;
  localparam int MAX_JOINTS = 3;
  localparam int JIDX_W     = 2;
  localparam int ADDR_W     = 5;
  localparam int STEP_W     = 6;

  localparam logic [STEP_W-1:0] DIV_LAST  = '1;
  localparam logic [STEP_W-1:0] KDIV_LAST = 6'd7;

  localparam logic [21:0] DUR_RESET = 22'd2000000;
  localparam logic [15:0] KP_RESET  = 16'd4915;
  localparam logic [15:0] KI_RESET  = 16'd819;

  // 1000000 = 64 * 15625; the 15625 part is a reciprocal multiply on 30-bit chunks
  localparam logic [13:0] KDIV_D = 14'd15625;
  localparam logic [30:0] KDIV_M = 31'd1125899907;  // floor(2^44 / 15625) + 1

  typedef enum logic {
    OPC_START = 1'b0,
    OPC_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_TGT0 = 3'd0,
    REG_TGT1 = 3'd1,
    REG_TGT2 = 3'd2,
    REG_DUR  = 3'd3,
    REG_KP   = 3'd4,
    REG_KI   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [MAX_JOINTS-1:0][15:0] target;
    logic [21:0]                 duration;
    logic [15:0]                 kp;
    logic [15:0]                 ki;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_DIVU_LD, OP_DIV_STEP, OP_MUL_UU, OP_GET_U2, OP_MUL_U2U,
    OP_GET_U3, OP_MUL_S, OP_GET_S, OP_MUL_REF, OP_GET_E, OP_MUL_EDT, OP_GET_I,
    OP_MUL_KP, OP_GET_PT, OP_MUL_KLO, OP_GET_LO, OP_MUL_KHI, OP_GET_FULL,
    OP_DIVK_LD, OP_KMUL, OP_KGET, OP_GET_Q, OP_FIN_J, OP_TIME, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIVU_LD, ST_DIVU, ST_MUL_UU, ST_GET_U2, ST_MUL_U2U, ST_GET_U3,
    ST_MUL_S, ST_GET_S, ST_MUL_REF, ST_GET_E, ST_MUL_EDT, ST_GET_I, ST_MUL_KP,
    ST_GET_PT, ST_MUL_KLO, ST_GET_LO, ST_MUL_KHI, ST_GET_FULL, ST_DIVK_LD, ST_DIVK,
    ST_GET_Q, ST_FIN_J, ST_TIME, ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t            op;
    logic [JIDX_W-1:0] joint;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/qtpi_regs.sv @@
// Configuration register file with APB-style access.
`default_nettype none
module qtpi_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [qtpi_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output qtpi_pkg::cfg_t                  cfg
);
  import qtpi_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target   <= '0;
      cfg.duration <= DUR_RESET;
      cfg.kp       <= KP_RESET;
      cfg.ki       <= KI_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_TGT0: cfg.target[0] <= pwdata[15:0];
        REG_TGT1: cfg.target[1] <= pwdata[15:0];
        REG_TGT2: cfg.target[2] <= pwdata[15:0];
        REG_DUR:  cfg.duration  <= pwdata[21:0];
        REG_KP:   cfg.kp        <= pwdata[15:0];
        REG_KI:   cfg.ki        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TGT0: prdata = {16'b0, cfg.target[0]};
      REG_TGT1: prdata = {16'b0, cfg.target[1]};
      REG_TGT2: prdata = {16'b0, cfg.target[2]};
      REG_DUR:  prdata = {10'b0, cfg.duration};
      REG_KP:   prdata = {16'b0, cfg.kp};
      REG_KI:   prdata = {16'b0, cfg.ki};
      default:  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/qtpi_ctrl.sv @@
// Sequencing state machine: handshakes and datapath commands.
`default_nettype none
module qtpi_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire qtpi_pkg::dp_stat_t stat,
  output qtpi_pkg::dp_cmd_t       cmd
);
  import qtpi_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  logic [JIDX_W-1:0] joint;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      joint     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIVU_LD || state == ST_DIVK_LD) step <= '0;
      else if (state == ST_DIVU || state == ST_DIVK) step <= step + 1'b1;
      if (state == ST_DIVU_LD) joint <= '0;
      else if (state == ST_FIN_J) joint <= joint + 1'b1;
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (in_valid) begin
          state_next = (opcode == OPC_TICK && stat.active) ? ST_DIVU_LD : ST_OUT;
        end
      ST_DIVU_LD:  state_next = ST_DIVU;
      ST_DIVU:     if (step == DIV_LAST) state_next = ST_MUL_UU;
      ST_MUL_UU:   state_next = ST_GET_U2;
      ST_GET_U2:   state_next = ST_MUL_U2U;
      ST_MUL_U2U:  state_next = ST_GET_U3;
      ST_GET_U3:   state_next = ST_MUL_S;
      ST_MUL_S:    state_next = ST_GET_S;
      ST_GET_S:    state_next = ST_MUL_REF;
      ST_MUL_REF:  state_next = ST_GET_E;
      ST_GET_E:    state_next = ST_MUL_EDT;
      ST_MUL_EDT:  state_next = ST_GET_I;
      ST_GET_I:    state_next = ST_MUL_KP;
      ST_MUL_KP:   state_next = ST_GET_PT;
      ST_GET_PT:   state_next = ST_MUL_KLO;
      ST_MUL_KLO:  state_next = ST_GET_LO;
      ST_GET_LO:   state_next = ST_MUL_KHI;
      ST_MUL_KHI:  state_next = ST_GET_FULL;
      ST_GET_FULL: state_next = ST_DIVK_LD;
      ST_DIVK_LD:  state_next = ST_DIVK;
      ST_DIVK:     if (step == KDIV_LAST) state_next = ST_GET_Q;
      ST_GET_Q:    state_next = ST_FIN_J;
      ST_FIN_J:
        state_next = (joint == JIDX_W'(NUM_JOINTS - 1)) ? ST_TIME : ST_MUL_REF;
      ST_TIME:     state_next = ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.joint = joint;
    case (state)
      ST_IDLE:     cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
      ST_DIVU_LD:  cmd.op = OP_DIVU_LD;
      ST_DIVU:     cmd.op = OP_DIV_STEP;
      ST_MUL_UU:   cmd.op = OP_MUL_UU;
      ST_GET_U2:   cmd.op = OP_GET_U2;
      ST_MUL_U2U:  cmd.op = OP_MUL_U2U;
      ST_GET_U3:   cmd.op = OP_GET_U3;
      ST_MUL_S:    cmd.op = OP_MUL_S;
      ST_GET_S:    cmd.op = OP_GET_S;
      ST_MUL_REF:  cmd.op = OP_MUL_REF;
      ST_GET_E:    cmd.op = OP_GET_E;
      ST_MUL_EDT:  cmd.op = OP_MUL_EDT;
      ST_GET_I:    cmd.op = OP_GET_I;
      ST_MUL_KP:   cmd.op = OP_MUL_KP;
      ST_GET_PT:   cmd.op = OP_GET_PT;
      ST_MUL_KLO:  cmd.op = OP_MUL_KLO;
      ST_GET_LO:   cmd.op = OP_GET_LO;
      ST_MUL_KHI:  cmd.op = OP_MUL_KHI;
      ST_GET_FULL: cmd.op = OP_GET_FULL;
      ST_DIVK_LD:  cmd.op = OP_DIVK_LD;
      // a multiply step then a get step per 16-bit quotient chunk
      ST_DIVK:     cmd.op = step[0] ? OP_KGET : OP_KMUL;
      ST_GET_Q:    cmd.op = OP_GET_Q;
      ST_FIN_J:    cmd.op = OP_FIN_J;
      ST_TIME:     cmd.op = OP_TIME;
      ST_OUT:      cmd.op = out_free ? OP_OUT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/qtpi_dpath.sv @@
// Datapath: trajectory state, shared multiplier, shift-subtract divider, PI math.
`default_nettype none
module qtpi_dpath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire qtpi_pkg::dp_cmd_t                     cmd,
  output qtpi_pkg::dp_stat_t                         stat,
  input  wire qtpi_pkg::cfg_t                        cfg,
  input  wire logic                                  opcode,
  input  wire logic [qtpi_pkg::MAX_JOINTS-1:0][15:0] angles,
  input  wire logic [15:0]                           elapsed_us,
  output logic [qtpi_pkg::MAX_JOINTS-1:0][23:0]      torques,
  output logic                                       done_res
);
  import qtpi_pkg::*;

  // trajectory state
  logic signed [15:0] origin   [MAX_JOINTS];
  logic signed [16:0] distance [MAX_JOINTS];
  logic signed [47:0] integ    [MAX_JOINTS];
  logic signed [23:0] held     [MAX_JOINTS];
  logic signed [15:0] a_in     [MAX_JOINTS];
  logic [22:0]        ttime;
  logic               active;
  logic               done_flag;
  logic [15:0]        dt;

  // working registers
  logic [21:0]        div_r;
  logic [63:0]        div_q;
  logic [16:0]        u, u2, u3, s;
  logic signed [22:0] inner;
  logic signed [49:0] prod;
  logic signed [19:0] e;
  logic signed [35:0] pterm;
  logic [39:0]        plo;
  logic signed [63:0] full;
  logic               neg;
  logic signed [45:0] qs;
  logic [60:0]        kprod;

  // combinational helpers
  logic [21:0]        deff, tc;
  logic signed [24:0] ma, mb;
  logic signed [49:0] pr;
  logic signed [33:0] s_sh;
  logic [16:0]        s_next;
  logic signed [17:0] rq;
  logic signed [48:0] isum;
  logic signed [47:0] isat;
  logic signed [63:0] hi64;
  logic [22:0]        rs;
  logic               rge;
  logic signed [47:0] sumf, nf, tsh;
  logic signed [23:0] tq;
  logic [23:0]        tn_raw;
  logic [22:0]        tn;
  logic [JIDX_W-1:0]  j;
  logic [29:0]        kv, krem;
  logic [15:0]        kq;
  logic [63:0]        fmag;

  assign j           = cmd.joint;
  assign stat.active = active;
  assign deff        = (cfg.duration == '0) ? 22'd1 : cfg.duration;
  assign tc          = (ttime < 23'(deff)) ? ttime[21:0] : deff;
  assign pr          = prod + 50'sd32768;
  assign rs          = {div_r, div_q[63]};
  assign rge         = rs >= {1'b0, deff};
  // chunk = remainder:next 16 dividend bits, always below 15625 * 2^16
  assign kv          = {div_r[13:0], div_q[63:48]};
  assign kq          = kprod[59:44];
  assign krem        = kv - 30'(kq) * 30'(KDIV_D);
  assign fmag        = full[63] ? 64'(-full) : 64'(full);

  always_comb begin
    case (cmd.op)
      OP_MUL_UU:  begin ma = $signed({8'b0, div_q[16:0]}); mb = ma; end
      OP_MUL_U2U: begin ma = $signed({8'b0, u2}); mb = $signed({8'b0, u}); end
      OP_MUL_S:   begin ma = $signed({8'b0, u3}); mb = 25'(inner); end
      OP_MUL_REF: begin ma = 25'(distance[j]); mb = $signed({8'b0, s}); end
      OP_MUL_EDT: begin ma = 25'(e); mb = $signed({9'b0, dt}); end
      OP_MUL_KP:  begin ma = $signed({9'b0, cfg.kp}); mb = 25'(e); end
      OP_MUL_KLO: begin ma = $signed({9'b0, cfg.ki}); mb = $signed({1'b0, integ[j][23:0]}); end
      OP_MUL_KHI: begin ma = $signed({9'b0, cfg.ki}); mb = 25'($signed(integ[j][47:24])); end
      default:    begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    // blend factor clamped to [0, 1.0] in Q16
    s_sh = pr[49:16];
    if (pr[49]) s_next = '0;
    else if (s_sh > 34'sd65536) s_next = 17'd65536;
    else s_next = s_sh[16:0];
    rq   = pr[33:16];
    isum = 49'(integ[j]) + 49'($signed(prod[35:0]));
    if (isum[48] != isum[47]) isat = isum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    else isat = isum[47:0];
    hi64 = 64'($signed(prod[39:0]));
    sumf = 48'(pterm) + 48'(qs);
    nf   = 48'sd4096 - sumf;
    tsh  = nf >>> 13;
    if (tsh > 48'sd8388607) tq = 24'sh7FFFFF;
    else if (tsh < -48'sd8388608) tq = 24'sh800000;
    else tq = tsh[23:0];
    tn_raw = {1'b0, ttime} + 24'(dt);
    tn     = tn_raw[23] ? '1 : tn_raw[22:0];
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      for (int k = 0; k < MAX_JOINTS; k++) begin
        origin[k]   <= '0;
        distance[k] <= '0;
        integ[k]    <= '0;
        held[k]     <= '0;
      end
      ttime     <= '0;
      active    <= 1'b0;
      done_flag <= 1'b0;
      torques   <= '0;
      done_res  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          for (int k = 0; k < MAX_JOINTS; k++) a_in[k] <= angles[k];
          dt <= elapsed_us;
          if (opcode == OPC_START) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
              origin[k]   <= angles[k];
              distance[k] <= 17'($signed(cfg.target[k])) - 17'($signed(angles[k]));
              integ[k]    <= '0;
            end
            ttime     <= '0;
            active    <= 1'b1;
            done_flag <= 1'b0;
          end else if (!active) begin
            done_flag <= (ttime >= 23'(deff));
          end
        end
        OP_DIVU_LD: begin
          div_r <= '0;
          div_q <= {26'b0, tc, 16'b0};
        end
        OP_DIV_STEP: begin
          div_r <= rge ? 22'(rs - {1'b0, deff}) : rs[21:0];
          div_q <= {div_q[62:0], rge};
        end
        OP_MUL_UU: u <= div_q[16:0];
        OP_GET_U2: u2 <= pr[32:16];
        OP_GET_U3: begin
          u3    <= pr[32:16];
          inner <= 23'sd655360 + 23'sd6 * $signed({6'b0, u2}) - 23'sd15 * $signed({6'b0, u});
        end
        OP_GET_S: s <= s_next;
        OP_GET_E: e <= 20'(a_in[j]) - 20'(origin[j]) - 20'(rq);
        OP_GET_I: integ[j] <= isat;
        OP_GET_PT: pterm <= prod[35:0];
        OP_GET_LO: plo <= prod[39:0];
        OP_GET_FULL: full <= (hi64 <<< 24) + $signed({24'b0, plo});
        OP_DIVK_LD: begin
          neg   <= full[63];
          div_q <= {6'b0, fmag[63:6]};
          div_r <= '0;
        end
        // divide by 15625, 16 quotient bits per chunk, quotient shifts in at the bottom
        OP_KMUL: kprod <= 61'(kv) * 61'(KDIV_M);
        OP_KGET: begin
          div_r <= 22'(krem);
          div_q <= {div_q[47:0], kq};
        end
        // integral term truncates toward zero
        OP_GET_Q: qs <= neg ? -$signed({1'b0, div_q[44:0]}) : $signed({1'b0, div_q[44:0]});
        OP_FIN_J: held[j] <= tq;
        OP_TIME: begin
          ttime <= tn;
          if (tn >= 23'(deff)) begin
            active    <= 1'b0;
            done_flag <= 1'b1;
          end else begin
            done_flag <= 1'b0;
          end
        end
        OP_OUT: begin
          for (int k = 0; k < MAX_JOINTS; k++) begin
            torques[k] <= (k < NUM_JOINTS) ? held[k] : '0;
          end
          done_res <= done_flag;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/quintic_trajectory_pi_joint_control_unit.sv @@
// Top level: quintic minimum-jerk trajectory with per-joint PI torque control.
// Start items and idle ticks go to ST_OUT, which loads the output register, then to ST_IDLE.
// Active tick: a 64-step divider forms the blend factor, then each joint in turn runs its PI
// math and a ki scaling divide, and the time update precedes the output in ST_OUT.
// One item at a time; the next item is taken while a result waits in the output register.
// Synchronous active-high reset returns registers and trajectory state to defaults.
`default_nettype none
module quintic_trajectory_pi_joint_control_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        opcode,
  input  wire logic [15:0]                 angle_0,
  input  wire logic [15:0]                 angle_1,
  input  wire logic [15:0]                 angle_2,
  input  wire logic [15:0]                 elapsed_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [23:0]                      torque_0,
  output logic [23:0]                      torque_1,
  output logic [23:0]                      torque_2,
  output logic                             done_res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qtpi_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import qtpi_pkg::*;

  cfg_t                        cfg;
  dp_cmd_t                     cmd;
  dp_stat_t                    stat;
  logic [MAX_JOINTS-1:0][23:0] torques;
  logic [MAX_JOINTS-1:0][15:0] angles;

  assign pready   = 1'b1;
  assign angles   = {angle_2, angle_1, angle_0};
  assign torque_0 = torques[0];
  assign torque_1 = torques[1];
  assign torque_2 = torques[2];

  qtpi_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  qtpi_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .opcode, .out_valid, .out_stall, .stat, .cmd
  );

  qtpi_dpath u_dpath (
    .clk, .rst, .cmd, .stat, .cfg, .opcode, .angles, .elapsed_us, .torques, .done_res
  );

endmodule
`default_nettype wire

@@ rtl/qtpi_checker.sv @@
// Port-level checker for the controller top level, with its bind.
`default_nettype none
module qtpi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] torque_0,
  input wire logic        done_res
);

  // one item in flight: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  // a new result only appears at the end of work on an item
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(torque_0) && $stable(done_res))
    else $error("stalled result changed");

endmodule

bind quintic_trajectory_pi_joint_control_unit qtpi_checker u_qtpi_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .torque_0, .done_res
);
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the quintic trajectory PI joint controller: directed and random items vs. a predictor.
`default_nettype none
class torque_scoreboard;
  typedef struct {
    logic [23:0] tq [3];
    logic        done;
  } torque_res_t;

  torque_res_t pending[$];
  int errors = 0;

  logic signed [15:0] target [3];
  logic [21:0] duration;
  logic [15:0] kp, ki;
  logic signed [15:0] origin [3];
  logic signed [16:0] distance [3];
  longint integ [3];
  longint held [3];
  int unsigned traj_t;
  bit active;

  function void reset_state();
    for (int j = 0; j < 3; j++) begin
      target[j] = 0; origin[j] = 0; distance[j] = 0; integ[j] = 0; held[j] = 0;
    end
    duration = 22'd2000000; kp = 16'd4915; ki = 16'd819;
    traj_t = 0; active = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] v);
    if (idx <= 2) target[idx] = v[15:0];
    else if (idx == 3) duration = v[21:0];
    else if (idx == 4) kp = v[15:0];
    else if (idx == 5) ki = v[15:0];
  endfunction

  function longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function longint blend(int unsigned t, longint d);
    longint tc, u, u2, u3, inner, s;
    tc = (t < d) ? t : d;
    u = (tc <<< 16) / d;
    u2 = (u * u + 32768) >>> 16;
    u3 = (u2 * u + 32768) >>> 16;
    inner = 655360 + 6 * u2 - 15 * u;
    s = fshift(u3 * inner + 32768, 16);
    if (s < 0) s = 0;
    if (s > 65536) s = 65536;
    return s;
  endfunction

  function void note_input(bit op, logic signed [15:0] ang [3], logic [15:0] dt_us);
    torque_res_t r;
    longint d, s, refv, e, acc, sum, tq, dt;
    bit done;
    d = (duration == 0) ? 1 : duration;
    done = 0;
    if (op == 1'b0) begin
      for (int j = 0; j < 3; j++) begin
        origin[j] = ang[j];
        distance[j] = 17'(target[j]) - 17'(ang[j]);
        integ[j] = 0;
      end
      traj_t = 0; active = 1;
    end else if (!active) begin
      done = (traj_t >= d);
    end else begin
      dt = dt_us;
      s = blend(traj_t, d);
      for (int j = 0; j < 3; j++) begin
        refv = longint'(origin[j]) + fshift(longint'(distance[j]) * s + 32768, 16);
        e = longint'(ang[j]) - refv;
        acc = integ[j] + e * dt;
        if (acc > 64'sh7FFFFFFFFFFF) acc = 64'sh7FFFFFFFFFFF;
        if (acc < -64'sh800000000000) acc = -64'sh800000000000;
        integ[j] = acc;
        sum = longint'(kp) * e + (longint'(ki) * acc) / 1000000;
        tq = fshift(4096 - sum, 13);
        if (tq > 8388607) tq = 8388607;
        if (tq < -8388608) tq = -8388608;
        held[j] = tq;
      end
      traj_t = traj_t + dt_us;
      if (traj_t > 32'h7FFFFF) traj_t = 32'h7FFFFF;
      if (traj_t >= d) begin
        active = 0; done = 1;
      end
    end
    for (int j = 0; j < 3; j++) r.tq[j] = held[j][23:0];
    r.done = done;
    pending.push_back(r);
  endfunction

  function void check_result(logic [23:0] t0, logic [23:0] t1, logic [23:0] t2, logic dn);
    torque_res_t x;
    logic [23:0] got [3];
    got[0] = t0; got[1] = t1; got[2] = t2;
    if (pending.size() == 0) begin
      $error("unexpected result transfer");
      errors++;
      return;
    end
    x = pending.pop_front();
    for (int j = 0; j < 3; j++)
      if (got[j] !== x.tq[j]) begin
        $error("torque_%0d expected %h got %h", j, x.tq[j], got[j]);
        errors++;
      end
    if (dn !== x.done) begin
      $error("done_res expected %b got %b", x.done, dn);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qtpi_pkg::*;

  logic clk, rst;
  logic in_valid, in_stall, opcode;
  logic [15:0] angle_0, angle_1, angle_2, elapsed_us;
  logic out_valid, out_stall;
  logic [23:0] torque_0, torque_1, torque_2;
  logic done_res;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  quintic_trajectory_pi_joint_control_unit dut (.*);

  torque_scoreboard sb = new();
  int send_idle, recv_idle;
  int quiet_cycles;
  localparam int QUIET_LIMIT = 20000;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_valid = 0; opcode = 0; angle_0 = 0; angle_1 = 0; angle_2 = 0; elapsed_us = 0;
    out_stall = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle);
    if (!rst && out_valid && !out_stall)
      sb.check_result(torque_0, torque_1, torque_2, done_res);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(4 * int'(idx)); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(int'(idx), v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic send_item(bit op, logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                           logic [15:0] dt);
    logic signed [15:0] ang [3];
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1; opcode <= op; angle_0 <= a0; angle_1 <= a1; angle_2 <= a2;
    elapsed_us <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ang[0] = a0; ang[1] = a1; ang[2] = a2;
    sb.note_input(op, ang, dt);
    in_valid <= 0;
    // the block is busy for at least this cycle after a transfer
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] t0, logic [15:0] t1, logic [15:0] t2,
                            logic [21:0] dur, logic [15:0] kpv, logic [15:0] kiv);
    drain();
    reg_write(REG_TGT0, {16'h0, t0});
    reg_write(REG_TGT1, {16'h0, t1});
    reg_write(REG_TGT2, {16'h0, t2});
    reg_write(REG_DUR, {10'h0, dur});
    reg_write(REG_KP, {16'h0, kpv});
    reg_write(REG_KI, {16'h0, kiv});
  endtask

  task automatic rand_phase(int n, int s_idle, int r_idle);
    int left;
    logic [15:0] dmax;
    send_idle = s_idle; recv_idle = r_idle;
    left = n;
    while (left > 0) begin
      case ($urandom_range(3))
        0: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                      22'($urandom_range(1, 200)), 16'($urandom), 16'($urandom));
        1: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                      22'($urandom_range(1000, 4000000)), 16'($urandom_range(0, 8000)),
                      16'($urandom));
        2: set_config(16'($urandom), 16'($urandom), 16'($urandom), 22'd0, 16'hFFFF,
                      16'hFFFF);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom), 22'h3FFFFF,
                            16'd0, 16'd0);
      endcase
      dmax = ($urandom_range(1) != 0) ? 16'd300 : 16'hFFFF;
      send_item(OPC_START, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      left--;
      for (int k = 0; k < 12 && left > 0; k++) begin
        if ($urandom_range(9) == 0)
          send_item(OPC_START, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        else
          send_item(OPC_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, dmax)));
        left--;
      end
    end
  endtask

  initial begin
    send_idle = 0; recv_idle = 0;
    sb.reset_state();
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // a tick before any start, with reset config
    send_item(OPC_TICK, 16'h7FFF, 16'h8000, 16'h0, 16'hFFFF);
    send_item(OPC_START, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(OPC_TICK, 16'h7FFF, 16'h8000, 16'h1234, 16'd1000);
    send_item(OPC_TICK, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0);
    set_config(16'h7FFF, 16'h8000, 16'h0, 22'd0, 16'hFFFF, 16'hFFFF);
    send_item(OPC_START, 16'h8000, 16'h7FFF, 16'h0, 16'h0);
    send_item(OPC_TICK, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_item(OPC_TICK, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    set_config(16'h8000, 16'h7FFF, 16'h4000, 22'd4000000, 16'hFFFF, 16'hFFFF);
    send_item(OPC_START, 16'h7FFF, 16'h8000, 16'h0, 16'h0);
    for (int k = 0; k < 6; k++)
      send_item(OPC_TICK, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
    // duration lowered below elapsed time while tracking
    set_config(16'h100, 16'h200, 16'h300, 22'd100000, 16'd4915, 16'd819);
    send_item(OPC_START, 16'h0, 16'h10, 16'h20, 16'h0);
    send_item(OPC_TICK, 16'h5, 16'h15, 16'h25, 16'd50000);
    set_config(16'h100, 16'h200, 16'h300, 22'd10, 16'd4915, 16'd819);
    send_item(OPC_TICK, 16'h5, 16'h15, 16'h25, 16'd1);
    send_item(OPC_TICK, 16'h5, 16'h15, 16'h25, 16'd1);
    set_config(16'h0, 16'h0, 16'h0, 22'd1, 16'd0, 16'd0);
    send_item(OPC_START, 16'h0, 16'h0, 16'h0, 16'h0);
    send_item(OPC_TICK, 16'h0, 16'h0, 16'h0, 16'd1);
    send_item(OPC_TICK, 16'h0, 16'h0, 16'h0, 16'd1);

    rand_phase(380, 35, 48);
    // sender holds off until the block has answered everything
    while (sb.pending.size() != 0) @(posedge clk);
    rand_phase(380, 48, 35);
    rand_phase(380, 0, 0);

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/qtpi_pkg.sv
rtl/qtpi_regs.sv
rtl/qtpi_ctrl.sv
rtl/qtpi_dpath.sv
rtl/quintic_trajectory_pi_joint_control_unit.sv
rtl/qtpi_checker.sv
dv/tb_top.sv
